@@ rtl/pss_pkg.sv @@
// Shared types and constants of the polyline spaced point sampler.
`default_nettype none
package pss_pkg;

  localparam int CoordW = 24;
  localparam int ThrW = 16;
  localparam int ResultCap = 64;
  localparam int ResCntW = $clog2(ResultCap + 1);
  localparam int RootSteps = 25;
  localparam int IterW = 5;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_NEXT = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [1:0] REG_SPACING = 2'd0;
  localparam logic [1:0] REG_SHIFT_X = 2'd1;
  localparam logic [1:0] REG_SHIFT_Y = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_NEXT,
    OP_CLOSE
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } item_t;

  typedef struct packed {
    logic [ThrW-1:0]          thr;
    logic signed [CoordW-1:0] shx;
    logic signed [CoordW-1:0] shy;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pend_v;
  } bstat_t;

  function automatic logic signed [CoordW-1:0] clamp25(input logic signed [CoordW:0] v);
    logic signed [CoordW-1:0] r;
    if (v[CoordW] != v[CoordW-1]) begin
      r = v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pss_front.sv @@
// Input side: accepts items, classifies the kind and queues them.
`default_nettype none
module pss_front (
  input  wire logic                              in_valid_i,
  input  wire logic [1:0]                        kind_i,
  input  wire logic signed [pss_pkg::CoordW-1:0] vertex_x_i,
  input  wire logic signed [pss_pkg::CoordW-1:0] vertex_y_i,
  output logic                                   in_stall_o,
  input  wire logic                              q_full_i,
  output logic                                   push_o,
  output pss_pkg::item_t                         item_o
);

  logic keep;

  always_comb begin
    keep = 1'b1;
    item_o.op = pss_pkg::OP_NEXT;
    item_o.x  = vertex_x_i;
    item_o.y  = vertex_y_i;
    unique case (kind_i)
      pss_pkg::KIND_START: item_o.op = pss_pkg::OP_START;
      pss_pkg::KIND_NEXT:  item_o.op = pss_pkg::OP_NEXT;
      pss_pkg::KIND_CLOSE: item_o.op = pss_pkg::OP_CLOSE;
      default:             keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  // Undefined kinds are taken and dropped.
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule
`default_nettype wire

@@ rtl/pss_queue.sv @@
// Two-entry queue between the front and the back.
`default_nettype none
module pss_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  pss_pkg::item_t   data_i,
  input  wire logic        pop_i,
  output pss_pkg::item_t   data_o,
  output logic             full_o,
  output logic             valid_o
);

  pss_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;

endmodule
`default_nettype wire

@@ rtl/pss_back.sv @@
// Segment engine: square root, unit-step divide, stepped walk and point output.
`default_nettype none
module pss_back #(
  parameter int MaxSteps = 64,
  parameter int FracBits = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  pss_pkg::cfg_t                          cfg_i,
  input  wire logic                              q_valid_i,
  input  pss_pkg::item_t                         item_i,
  output logic                                   pop_o,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [pss_pkg::CoordW-1:0]      point_x_o,
  output logic signed [pss_pkg::CoordW-1:0]      point_y_o,
  output logic                                   last_of_segment_o,
  output logic                                   steps_truncated_o,
  output pss_pkg::bstat_t                        stat_o
);

  localparam int CW_ = pss_pkg::CoordW;
  localparam int DW = CW_ + 1;
  localparam int SQW = 2 * DW;
  localparam int SW = SQW + 1;
  localparam int RMW = 29;
  localparam int QW = FracBits + 1;
  localparam int AW = FracBits + 2;
  localparam int STW = DW + 1;
  localparam int SCW = $clog2(MaxSteps + 1);
  localparam int UP = (FracBits >= 8) ? FracBits - 8 : 0;
  localparam int DOWN = (FracBits < 8) ? 8 - FracBits : 0;
  localparam int TW = pss_pkg::ThrW + UP;
  localparam int D2W = SW + 2 * DOWN;
  localparam int CMW = (D2W > 2 * TW) ? D2W : 2 * TW;
  localparam logic [STW-1:0] RoundAdd = STW'((1 << FracBits) - 1);
  localparam int IterW_ = pss_pkg::IterW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SUM, S_ROOT, S_SETUP, S_DIV, S_ADV, S_SQ, S_CMP, S_FLUSH, S_DONE
  } state_e;

  state_e state_q;
  logic signed [CW_-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, le_x_q, le_y_q;
  logic signed [CW_-1:0] tx_q, ty_q, px_q, py_q, ex_q, ey_q, ox_q, oy_q;
  logic signed [CW_-1:0] pend_x_q, pend_y_q;
  logic signed [DW-1:0]  dx_q, dy_q;
  logic [DW-1:0]         mx_q, my_q, root_q, lc_q, remx_q, remy_q;
  logic                  sx_q, sy_q, pre_q, trunc_q, pend_v_q;
  logic [SQW-1:0]        sqx_q, sqy_q;
  logic [SQW-1:0]        rad_q;
  logic [RMW-1:0]        rem_q;
  logic [IterW_-1:0]     it_q;
  logic [QW-1:0]         qx_q, qy_q, numx_q, numy_q;
  logic [SCW-1:0]        lim_q, n_q;
  logic [pss_pkg::ResCntW-1:0] cnt_q;
  logic [2*TW-1:0]       thr2_q;
  logic                  out_v_q, out_last_q, out_tr_q;
  logic signed [CW_-1:0] out_x_q, out_y_q;

  // Combinational helpers
  logic signed [DW-1:0]  ldx, ldy, ddx, ddy;
  logic signed [CW_-1:0] ltx, lty;
  logic [RMW-1:0]        rem_n, trial;
  logic [DW:0]           rnx, rny;
  logic [STW-1:0]        steps;
  logic [DW-1:0]         lc_n;
  logic signed [AW-1:0]  ax, ay;
  logic [DW-1:0]         adx, ady;
  logic [CMW-1:0]        lhs, rhs;
  logic                  far, slot_free, out_load;
  logic [TW-1:0]         tval;

  always_comb begin
    ltx = (item_i.op == pss_pkg::OP_CLOSE) ? first_x_q : item_i.x;
    lty = (item_i.op == pss_pkg::OP_CLOSE) ? first_y_q : item_i.y;
    ldx = {ltx[CW_-1], ltx} - {prev_x_q[CW_-1], prev_x_q};
    ldy = {lty[CW_-1], lty} - {prev_y_q[CW_-1], prev_y_q};
    rem_n = {rem_q[RMW-3:0], rad_q[SQW-1:SQW-2]};
    trial = RMW'({root_q, 2'b01});
    lc_n = root_q + DW'(rem_q != '0);
    steps = (STW'(lc_q) + RoundAdd) >> FracBits;
    rnx = {remx_q, numx_q[QW-1]};
    rny = {remy_q, numy_q[QW-1]};
    ax = sx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
    ay = sy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
    ddx = {px_q[CW_-1], px_q} - {ex_q[CW_-1], ex_q};
    ddy = {py_q[CW_-1], py_q} - {ey_q[CW_-1], ey_q};
    adx = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
    ady = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
    tval = TW'(cfg_i.thr) << UP;
    lhs = CMW'(SW'(sqx_q) + SW'(sqy_q)) << (2 * DOWN);
    rhs = CMW'(thr2_q);
    far = lhs > rhs;
    slot_free = !out_v_q || !out_stall_i;
    // a held point moves into the output register
    out_load = ((state_q == S_CMP) && far &&
                (cnt_q != pss_pkg::ResCntW'(pss_pkg::ResultCap)) &&
                !pre_q && pend_v_q && slot_free) ||
               ((state_q == S_FLUSH) && pend_v_q && slot_free);
  end

  assign pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      le_x_q    <= '0;
      le_y_q    <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      pre_q     <= 1'b0;
      trunc_q   <= 1'b0;
      it_q      <= '0;
      n_q       <= '0;
      cnt_q     <= '0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (item_i.op == pss_pkg::OP_START) begin
              first_x_q <= item_i.x;
              first_y_q <= item_i.y;
              prev_x_q  <= item_i.x;
              prev_y_q  <= item_i.y;
              le_x_q    <= item_i.x;
              le_y_q    <= item_i.y;
            end else begin
              tx_q    <= ltx;
              ty_q    <= lty;
              dx_q    <= ldx;
              dy_q    <= ldy;
              ex_q    <= le_x_q;
              ey_q    <= le_y_q;
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          sqx_q   <= SQW'(dx_q) * SQW'(dx_q);
          sqy_q   <= SQW'(dy_q) * SQW'(dy_q);
          mx_q    <= dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
          my_q    <= dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
          sx_q    <= dx_q[DW-1];
          sy_q    <= dy_q[DW-1];
          thr2_q  <= (2*TW)'(tval) * (2*TW)'(tval);
          state_q <= S_SUM;
        end
        S_SUM: begin
          rad_q   <= sqx_q + sqy_q;
          rem_q   <= '0;
          root_q  <= '0;
          it_q    <= '0;
          state_q <= ((SW'(sqx_q) + SW'(sqy_q)) == '0) ? S_DONE : S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle, two radicand bits in
          rad_q <= rad_q << 2;
          if (rem_n >= trial) begin
            rem_q  <= rem_n - trial;
            root_q <= {root_q[DW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_n;
            root_q <= {root_q[DW-2:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          if (it_q == IterW_'(pss_pkg::RootSteps - 1)) state_q <= S_SETUP;
        end
        S_SETUP: begin
          lc_q    <= lc_n;
          remx_q  <= mx_q >> 1;
          remy_q  <= my_q >> 1;
          numx_q  <= {mx_q[0], {FracBits{1'b0}}};
          numy_q  <= {my_q[0], {FracBits{1'b0}}};
          qx_q    <= '0;
          qy_q    <= '0;
          it_q    <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          numx_q <= numx_q << 1;
          numy_q <= numy_q << 1;
          if (rnx >= {1'b0, lc_q}) begin
            remx_q <= DW'(rnx - {1'b0, lc_q});
            qx_q   <= {qx_q[QW-2:0], 1'b1};
          end else begin
            remx_q <= DW'(rnx);
            qx_q   <= {qx_q[QW-2:0], 1'b0};
          end
          if (rny >= {1'b0, lc_q}) begin
            remy_q <= DW'(rny - {1'b0, lc_q});
            qy_q   <= {qy_q[QW-2:0], 1'b1};
          end else begin
            remy_q <= DW'(rny);
            qy_q   <= {qy_q[QW-2:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          if (it_q == IterW_'(FracBits)) begin
            if (steps > STW'(MaxSteps)) begin
              lim_q   <= SCW'(MaxSteps);
              trunc_q <= 1'b1;
              pre_q   <= MaxSteps > pss_pkg::ResultCap;
            end else begin
              lim_q   <= steps[SCW-1:0];
              trunc_q <= 1'b0;
              pre_q   <= int'(steps) > pss_pkg::ResultCap;
            end
            px_q    <= prev_x_q;
            py_q    <= prev_y_q;
            n_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          if (n_q == lim_q) begin
            if (pre_q) begin
              // counting pass over; rewalk and emit
              pre_q   <= 1'b0;
              px_q    <= prev_x_q;
              py_q    <= prev_y_q;
              ex_q    <= le_x_q;
              ey_q    <= le_y_q;
              n_q     <= '0;
              cnt_q   <= '0;
            end else begin
              state_q <= S_FLUSH;
            end
          end else begin
            px_q    <= pss_pkg::clamp25({px_q[CW_-1], px_q} + DW'(ax));
            py_q    <= pss_pkg::clamp25({py_q[CW_-1], py_q} + DW'(ay));
            n_q     <= n_q + 1'b1;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sqx_q   <= SQW'(adx) * SQW'(adx);
          sqy_q   <= SQW'(ady) * SQW'(ady);
          ox_q    <= pss_pkg::clamp25({px_q[CW_-1], px_q} + {cfg_i.shx[CW_-1], cfg_i.shx});
          oy_q    <= pss_pkg::clamp25({py_q[CW_-1], py_q} + {cfg_i.shy[CW_-1], cfg_i.shy});
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (!far) begin
            state_q <= S_ADV;
          end else if (cnt_q == pss_pkg::ResCntW'(pss_pkg::ResultCap)) begin
            trunc_q <= 1'b1;
            if (pre_q) begin
              pre_q   <= 1'b0;
              px_q    <= prev_x_q;
              py_q    <= prev_y_q;
              ex_q    <= le_x_q;
              ey_q    <= le_y_q;
              n_q     <= '0;
              cnt_q   <= '0;
              state_q <= S_ADV;
            end else begin
              state_q <= S_FLUSH;
            end
          end else if (pre_q || !pend_v_q || slot_free) begin
            cnt_q <= cnt_q + 1'b1;
            ex_q  <= px_q;
            ey_q  <= py_q;
            if (!pre_q) begin
              if (pend_v_q) begin
                out_x_q    <= pend_x_q;
                out_y_q    <= pend_y_q;
                out_last_q <= 1'b0;
                out_tr_q   <= trunc_q;
              end
              pend_v_q <= 1'b1;
              pend_x_q <= ox_q;
              pend_y_q <= oy_q;
            end
            state_q <= S_ADV;
          end
        end
        S_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= S_DONE;
          end else if (slot_free) begin
            out_x_q    <= pend_x_q;
            out_y_q    <= pend_y_q;
            out_last_q <= 1'b1;
            out_tr_q   <= trunc_q;
            pend_v_q   <= 1'b0;
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          prev_x_q <= tx_q;
          prev_y_q <= ty_q;
          le_x_q   <= ex_q;
          le_y_q   <= ey_q;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_v_q;
  assign point_x_o         = out_x_q;
  assign point_y_o         = out_y_q;
  assign last_of_segment_o = out_last_q;
  assign steps_truncated_o = out_tr_q;
  assign stat_o.busy       = state_q != S_IDLE;
  assign stat_o.pend_v     = pend_v_q;

endmodule
`default_nettype wire

@@ rtl/polyline_spaced_point_sampler_top.sv @@
// Top level of the polyline spaced point sampler.
// A start item only sets the segment origin, and a zero-length segment skips the walk.
// Any other next or close item runs a bit-serial square root and a unit-step divide
// before its first step, then walks min(ceil(length), MAX_STEPS) steps and finishes;
// when MAX_STEPS exceeds 64 and a segment walks more than 64 steps, the walk runs
// twice (a counting pass first). Stalls on the output register can hold the walk.
// A two-entry queue decouples input acceptance.
`default_nettype none
module polyline_spaced_point_sampler_top #(
  parameter int MAX_STEPS = 64,
  parameter int COORD_FRAC_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [23:0]                       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        kind_i,
  input  wire logic signed [23:0]                vertex_x_i,
  input  wire logic signed [23:0]                vertex_y_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [23:0]                     point_x_o,
  output logic signed [23:0]                     point_y_o,
  output logic                                   last_of_segment_o,
  output logic                                   steps_truncated_o
);

  pss_pkg::cfg_t   cfg_q;
  pss_pkg::item_t  f_item, q_item;
  pss_pkg::bstat_t bst;
  logic            q_push, q_pop, q_full, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr <= 16'd768;
      cfg_q.shx <= '0;
      cfg_q.shy <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pss_pkg::REG_SPACING: cfg_q.thr <= cfg_data_i[15:0];
        pss_pkg::REG_SHIFT_X: cfg_q.shx <= cfg_data_i;
        pss_pkg::REG_SHIFT_Y: cfg_q.shy <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pss_front u_front (
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .vertex_x_i (vertex_x_i),
    .vertex_y_i (vertex_y_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (f_item)
  );

  pss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (f_item),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .full_o  (q_full),
    .valid_o (q_valid)
  );

  pss_back #(
    .MaxSteps (MAX_STEPS),
    .FracBits (COORD_FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .item_i            (q_item),
    .pop_o             (q_pop),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .point_x_o         (point_x_o),
    .point_y_o         (point_y_o),
    .last_of_segment_o (last_of_segment_o),
    .steps_truncated_o (steps_truncated_o),
    .stat_o            (bst)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue push while full");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bst.busy |-> !bst.pend_v) else $error("pending point left after segment");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for the polyline spaced point sampler: scoreboard, stimulus and checks.
`timescale 1ns / 100ps
module testbench;

  localparam int MaxSteps = 64;
  localparam int FracBits = 8;
  localparam longint CMin = -64'sd8388608;
  localparam longint CMax = 64'sd8388607;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic               last;
    logic               trunc;
  } point_t;

  class point_scoreboard;
    point_t  pending[$];
    int      mismatches;
    longint  thr, shx, shy;
    longint  first_x, first_y, prev_x, prev_y, emit_x, emit_y;

    function void clear_state();
      thr = 768; shx = 0; shy = 0;
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; emit_x = 0; emit_y = 0;
    endfunction

    function longint clamp(longint v);
      if (v < CMin) return CMin;
      if (v > CMax) return CMax;
      return v;
    endfunction

    function longint magn(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint root_ceil(longint s);
      longint r;
      r = longint'($sqrt(real'(s)));
      while (r * r > s) r--;
      while (r * r < s) r++;
      return r;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == pss_pkg::REG_SPACING) thr = longint'(val[15:0]);
      else if (idx == pss_pkg::REG_SHIFT_X) shx = longint'($signed(val));
      else if (idx == pss_pkg::REG_SHIFT_Y) shy = longint'($signed(val));
    endfunction

    function void walk_to(longint tx, longint ty);
      longint dx, dy, s, lc, steps, ax, ay, px, py, lim, d2, ex, ey, n;
      bit     trunc;
      point_t seg[$];
      point_t p;
      dx = tx - prev_x; dy = ty - prev_y;
      s = dx * dx + dy * dy;
      if (s != 0) begin
        lc = root_ceil(s);
        steps = (lc + (1 << FracBits) - 1) >> FracBits;
        ax = (magn(dx) << FracBits) / lc; if (dx < 0) ax = -ax;
        ay = (magn(dy) << FracBits) / lc; if (dy < 0) ay = -ay;
        px = prev_x; py = prev_y;
        trunc = steps > MaxSteps;
        lim = trunc ? MaxSteps : steps;
        for (n = 0; n < lim; n++) begin
          px = clamp(px + ax); py = clamp(py + ay);
          ex = px - emit_x; ey = py - emit_y;
          d2 = ex * ex + ey * ey;
          if (d2 > thr * thr) begin
            if (seg.size() >= pss_pkg::ResultCap) begin
              trunc = 1;
              break;
            end
            p.px = 24'(clamp(px + shx)); p.py = 24'(clamp(py + shy));
            p.last = 0; p.trunc = 0;
            seg.insert(seg.size(), p);
            emit_x = px; emit_y = py;
          end
        end
        foreach (seg[i]) begin
          seg[i].trunc = trunc;
          if (i == seg.size() - 1) seg[i].last = 1;
          pending.insert(pending.size(), seg[i]);
        end
      end
      prev_x = tx; prev_y = ty;
    endfunction

    function void note_vertex(logic [1:0] k, logic signed [23:0] x, logic signed [23:0] y);
      if (k == pss_pkg::KIND_START) begin
        first_x = x; first_y = y; prev_x = x; prev_y = y; emit_x = x; emit_y = y;
      end else if (k == pss_pkg::KIND_NEXT) walk_to(x, y);
      else if (k == pss_pkg::KIND_CLOSE) walk_to(first_x, first_y);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point x=%0d y=%0d", got.px, got.py);
        return;
      end
      want = pending.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.last !== want.last ||
          got.trunc !== want.trunc) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"point mismatch: expected x=%0d y=%0d last=%0b trunc=%0b, ",
                    "got x=%0d y=%0d last=%0b trunc=%0b"},
                   want.px, want.py, want.last, want.trunc,
                   got.px, got.py, got.last, got.trunc);
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [1:0]         kind_i = '0;
  logic signed [23:0] vertex_x_i = '0;
  logic signed [23:0] vertex_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [23:0] point_x_o;
  logic signed [23:0] point_y_o;
  logic               last_of_segment_o;
  logic               steps_truncated_o;

  point_scoreboard sb;
  bit              calm = 0;

  polyline_spaced_point_sampler_top #(.MAX_STEPS(MaxSteps), .COORD_FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .vertex_x_i, .vertex_y_i,
    .out_valid_o, .out_stall_i, .point_x_o, .point_y_o,
    .last_of_segment_o, .steps_truncated_o
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #200ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall bursts, check each transaction.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_stall_i <= 1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 0;
    end
  end

  always @(posedge clk_i) begin
    point_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.px = point_x_o; got.py = point_y_o;
      got.last = last_of_segment_o; got.trunc = steps_truncated_o;
      sb.check_point(got);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic send_vertex(logic [1:0] k, logic signed [23:0] x, logic signed [23:0] y);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1; kind_i <= k; vertex_x_i <= x; vertex_y_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_vertex(k, x, y);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    // segments that emit nothing may still be walking, two more may wait queued
    repeat (1000) @(negedge clk_i);
  endtask

  // One outline with small random segments around a random origin.
  task automatic random_outline(int span);
    int cx, cy, nv;
    cx = $urandom_range(0, 2000) - 1000; cy = $urandom_range(0, 2000) - 1000;
    nv = $urandom_range(1, 5);
    send_vertex(pss_pkg::KIND_START, 24'(cx), 24'(cy));
    repeat (nv)
      send_vertex(pss_pkg::KIND_NEXT, 24'(cx + $urandom_range(0, 2 * span) - span),
                  24'(cy + $urandom_range(0, 2 * span) - span));
    send_vertex(pss_pkg::KIND_CLOSE, 24'($urandom), 24'($urandom));
  endtask

  initial begin
    int count;
    sb = new();
    sb.clear_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    repeat (2) @(negedge clk_i);

    // Directed: next before any start, extremes, zero length, truncation, bad kind.
    send_vertex(pss_pkg::KIND_NEXT, 24'sd2560, 24'sd0);
    send_vertex(pss_pkg::KIND_START, 24'sd0, 24'sd0);
    send_vertex(pss_pkg::KIND_NEXT, 24'sd0, 24'sd0);
    send_vertex(pss_pkg::KIND_NEXT, 24'sd1280, 24'sd1280);
    send_vertex(pss_pkg::KIND_CLOSE, 24'sd0, 24'sd0);
    send_vertex(2'd3, 24'sd5000, -24'sd5000);
    send_vertex(pss_pkg::KIND_NEXT, 24'sd30000, -24'sd20000);
    send_vertex(pss_pkg::KIND_START, 24'sh7fffff, 24'sh800000);
    send_vertex(pss_pkg::KIND_NEXT, 24'sh7fff00, 24'sh800100);
    send_vertex(pss_pkg::KIND_NEXT, 24'sh7fffff, 24'sh7fffff);
    send_vertex(pss_pkg::KIND_CLOSE, 24'sd0, 24'sd0);
    drain();

    write_reg(pss_pkg::REG_SPACING, 24'd0);
    write_reg(pss_pkg::REG_SHIFT_X, 24'h7fffff);
    write_reg(pss_pkg::REG_SHIFT_Y, 24'h800000);
    send_vertex(pss_pkg::KIND_START, -24'sd1000, 24'sd1000);
    send_vertex(pss_pkg::KIND_NEXT, 24'sd3000, -24'sd3000);
    send_vertex(pss_pkg::KIND_NEXT, 24'sd3000, 24'sd9000);
    send_vertex(pss_pkg::KIND_CLOSE, 24'sd0, 24'sd0);
    drain();

    write_reg(pss_pkg::REG_SPACING, 24'hffff);
    write_reg(pss_pkg::REG_SHIFT_X, 24'h800000);
    write_reg(pss_pkg::REG_SHIFT_Y, 24'h7fffff);
    send_vertex(pss_pkg::KIND_START, 24'sh800000, 24'sh800000);
    send_vertex(pss_pkg::KIND_NEXT, 24'sh7fffff, 24'sh7fffff);
    send_vertex(pss_pkg::KIND_CLOSE, 24'sd0, 24'sd0);
    drain();

    // Random phases with varied settings; the last one runs without idling.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(pss_pkg::REG_SPACING, (ph == 0) ? 24'd768 : 24'($urandom_range(0, 2000)));
      write_reg(pss_pkg::REG_SHIFT_X, 24'($urandom_range(0, 4000) - 2000));
      write_reg(pss_pkg::REG_SHIFT_Y, 24'($urandom_range(0, 4000) - 2000));
      if (ph == 3) calm = 1;
      count = 0;
      while (count < 22) begin
        if ($urandom_range(0, 9) == 0) begin
          send_vertex(2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom));
          count++;
        end else begin
          random_outline($urandom_range(0, 3) == 0 ? 12000 : 2500);
          count += 5;
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
